/* design/vpa3_pkg.sv */
`timescale 1ns / 1ps

package vpa3_pkg;

    // widths fixed by the item fields
    localparam int FIELD_W = 16;
    localparam int PROD_W  = 2 * FIELD_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int OUT_W   = 16;

    // tolerance register
    localparam int                 CFG_W     = 15;
    localparam logic [CFG_W-1:0]   TOL_RESET = 15'd1;

    // default fraction bits of the fixed-point format
    localparam int DEF_FRAC_BITS = 14;

    typedef logic signed [FIELD_W-1:0] t_comp;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

endpackage

/* design/vpa3_round.sv */
`timescale 1ns / 1ps

// registered rounding of a value with 2*FRAC_BITS fraction bits down to FRAC_BITS,
// halves rounded away from zero
module vpa3_round #(
    parameter int IN_W      = vpa3_pkg::SUM_W,
    parameter int FRAC_BITS = vpa3_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic signed [IN_W-1:0]          i_x,
    output logic signed [IN_W-FRAC_BITS:0]  o_y
);

    localparam int RW = IN_W + 1 - FRAC_BITS;
    localparam logic [IN_W:0] HALF = {{IN_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic              neg;
    logic [IN_W:0]     mag;
    logic [IN_W:0]     biased;
    logic [IN_W:0]     shifted;
    logic [RW-1:0]     q;
    logic [RW-1:0]     n_y;

    // magnitude, bias by one half, truncate, restore sign
    always_comb begin
        neg     = i_x[IN_W-1];
        mag     = neg ? ({(IN_W+1){1'b0}} - {i_x[IN_W-1], i_x}) : {i_x[IN_W-1], i_x};
        biased  = mag + HALF;
        shifted = biased >> FRAC_BITS;
        q       = shifted[RW-1:0];
        n_y     = neg ? ({RW{1'b0}} - q) : q;
    end

    always_ff @(posedge i_clk) begin
        o_y <= $signed(n_y);
    end

endmodule

/* design/vector_pseudo_angle_3d.sv */
`timescale 1ns / 1ps

// Pseudo-angle between two unit 3D vectors, seen from a view direction.
// Command channel: an item (a, b, view, no_view) is taken at a rising edge
// with start high and busy low. busy stays low: the pipeline takes one item
// every cycle with no gaps.
// Result channel: o_valid marks one cycle in which o_measure, o_is_collinear
// and o_is_perpendicular hold the result; it is taken at the edge ending that
// cycle. Results leave in the order items came in.
// Each item passes the product, sum, rounding, square and output registers;
// throughput one item per cycle. The depth is set by the chain
// products -> sums -> rounding and cross.view products -> squares -> compare.
// The receiver cannot stall, so there is no backpressure path.
// Tolerance: written through i_cfg_we / i_cfg_data while no item is in
// flight; its square is registered from it in the following cycle.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the
// tolerance to 1.
module vector_pseudo_angle_3d #(
    parameter int FRAC_BITS = vpa3_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [vpa3_pkg::CFG_W-1:0]    i_cfg_data,
    input  vpa3_pkg::t_comp               i_a_x,
    input  vpa3_pkg::t_comp               i_a_y,
    input  vpa3_pkg::t_comp               i_a_z,
    input  vpa3_pkg::t_comp               i_b_x,
    input  vpa3_pkg::t_comp               i_b_y,
    input  vpa3_pkg::t_comp               i_b_z,
    input  vpa3_pkg::t_comp               i_view_x,
    input  vpa3_pkg::t_comp               i_view_y,
    input  vpa3_pkg::t_comp               i_view_z,
    input  logic                          i_no_view,
    output logic                          o_valid,
    output logic [vpa3_pkg::OUT_W-1:0]    o_measure,
    output logic                          o_is_collinear,
    output logic                          o_is_perpendicular
);

    localparam int FW    = vpa3_pkg::FIELD_W;
    localparam int SUM_W = vpa3_pkg::SUM_W;
    localparam int CFG_W = vpa3_pkg::CFG_W;
    localparam int OW    = vpa3_pkg::OUT_W;
    localparam int RW    = SUM_W + 1 - FRAC_BITS;      // rounded dot / cross width
    localparam int CV_W  = SUM_W + FW;                 // cross * view product
    localparam int CVS_W = CV_W + 2;                   // sum of three of them
    localparam int SQ_W  = 2 * RW;                     // square of a rounded cross term
    localparam int CSQ_W = SQ_W + 2;                   // sum of three squares
    localparam int TSQ_W = 2 * CFG_W;
    localparam int XW    = CSQ_W + TSQ_W;              // common compare width
    localparam int AW    = RW + CFG_W + 1;             // |dot| vs tolerance width
    localparam int MW    = ((RW > FRAC_BITS + 3) ? RW : FRAC_BITS + 3) + 1;
    localparam int DEPTH = 5;

    // measure constants, saturated to the output range
    localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
    localparam longint TOP_L  = ((4 * ONE_L - 1) > 65535) ? 65535 : (4 * ONE_L - 1);
    localparam logic [OW-1:0] M_TOP = OW'(TOP_L);
    localparam logic [OW-1:0] M_ONE = OW'((ONE_L > TOP_L) ? TOP_L : ONE_L);
    localparam logic [OW-1:0] M_TWO = OW'((2 * ONE_L > TOP_L) ? TOP_L : 2 * ONE_L);
    localparam logic [OW-1:0] M_THR = OW'((3 * ONE_L > TOP_L) ? TOP_L : 3 * ONE_L);
    localparam logic signed [MW-1:0] ONE_W = {{(MW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [MW-1:0] THR_W = ONE_W + (ONE_W <<< 1);
    localparam logic signed [MW-1:0] TOP_W = MW'(TOP_L);

    function automatic vpa3_pkg::t_sum sx(input vpa3_pkg::t_prod v);
        return {v[vpa3_pkg::PROD_W-1], v};
    endfunction

    function automatic logic signed [CVS_W-1:0] sxc(input logic signed [CV_W-1:0] v);
        return {{2{v[CV_W-1]}}, v};
    endfunction

    // clamp a candidate measure into [0, top]
    function automatic logic [OW-1:0] sat(input logic signed [MW-1:0] v);
        logic [OW-1:0] r;
        if (v[MW-1]) begin
            r = '0;
        end else if (v > TOP_W) begin
            r = M_TOP;
        end else begin
            r = v[OW-1:0];
        end
        return r;
    endfunction

    // tolerance register and its square
    logic [CFG_W-1:0] r_tol;
    logic [TSQ_W-1:0] r_tol_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= vpa3_pkg::TOL_RESET;
            r_tol_sq <= TSQ_W'(vpa3_pkg::TOL_RESET);
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            r_tol_sq <= r_tol * r_tol;
        end
    end

    // valid bits that travel with the stages
    logic             accept;
    logic [DEPTH-1:0] r_vld;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], accept};
        end
    end

    // stage 1: component products
    vpa3_pkg::t_prod r1_axbx, r1_ayby, r1_azbz;
    vpa3_pkg::t_prod r1_aybz, r1_azby, r1_azbx, r1_axbz, r1_axby, r1_aybx;
    vpa3_pkg::t_comp r1_vx, r1_vy, r1_vz;
    logic            r1_nv;

    always_ff @(posedge i_clk) begin
        r1_axbx <= i_a_x * i_b_x;
        r1_ayby <= i_a_y * i_b_y;
        r1_azbz <= i_a_z * i_b_z;
        r1_aybz <= i_a_y * i_b_z;
        r1_azby <= i_a_z * i_b_y;
        r1_azbx <= i_a_z * i_b_x;
        r1_axbz <= i_a_x * i_b_z;
        r1_axby <= i_a_x * i_b_y;
        r1_aybx <= i_a_y * i_b_x;
        r1_vx   <= i_view_x;
        r1_vy   <= i_view_y;
        r1_vz   <= i_view_z;
        r1_nv   <= i_no_view;
    end

    // stage 2: exact dot and cross products
    vpa3_pkg::t_sum  r2_dot, r2_cx, r2_cy, r2_cz;
    vpa3_pkg::t_comp r2_vx, r2_vy, r2_vz;
    logic            r2_nv;

    always_ff @(posedge i_clk) begin
        r2_dot <= sx(r1_axbx) + sx(r1_ayby) + sx(r1_azbz);
        r2_cx  <= sx(r1_aybz) - sx(r1_azby);
        r2_cy  <= sx(r1_azbx) - sx(r1_axbz);
        r2_cz  <= sx(r1_axby) - sx(r1_aybx);
        r2_vx  <= r1_vx;
        r2_vy  <= r1_vy;
        r2_vz  <= r1_vz;
        r2_nv  <= r1_nv;
    end

    // stage 3: rounding and cross.view products
    logic signed [RW-1:0]   r3_dot, r3_rx, r3_ry, r3_rz;
    logic signed [CV_W-1:0] r3_cvx, r3_cvy, r3_cvz;
    logic                   r3_nv;

    vpa3_round #(.IN_W(SUM_W), .FRAC_BITS(FRAC_BITS)) u_rnd_dot (
        .i_clk(i_clk), .i_x(r2_dot), .o_y(r3_dot)
    );
    vpa3_round #(.IN_W(SUM_W), .FRAC_BITS(FRAC_BITS)) u_rnd_cx (
        .i_clk(i_clk), .i_x(r2_cx), .o_y(r3_rx)
    );
    vpa3_round #(.IN_W(SUM_W), .FRAC_BITS(FRAC_BITS)) u_rnd_cy (
        .i_clk(i_clk), .i_x(r2_cy), .o_y(r3_ry)
    );
    vpa3_round #(.IN_W(SUM_W), .FRAC_BITS(FRAC_BITS)) u_rnd_cz (
        .i_clk(i_clk), .i_x(r2_cz), .o_y(r3_rz)
    );

    always_ff @(posedge i_clk) begin
        r3_cvx <= r2_cx * r2_vx;
        r3_cvy <= r2_cy * r2_vy;
        r3_cvz <= r2_cz * r2_vz;
        r3_nv  <= r2_nv;
    end

    // stage 4: squares, turn direction, perpendicular test, candidate measures
    logic signed [CVS_W-1:0] cv_sum;
    logic [RW:0]             dot_abs;
    logic                    perp;
    logic signed [MW-1:0]    dot_w;
    logic [OW-1:0]           n_m_pos, n_m_neg;

    always_comb begin
        cv_sum  = sxc(r3_cvx) + sxc(r3_cvy) + sxc(r3_cvz);
        dot_abs = r3_dot[RW-1] ? ({(RW+1){1'b0}} - {r3_dot[RW-1], r3_dot})
                               : {r3_dot[RW-1], r3_dot};
        perp    = AW'(dot_abs) <= AW'(r_tol);
        dot_w   = {{(MW-RW){r3_dot[RW-1]}}, r3_dot};
        n_m_pos = perp ? M_ONE : sat(ONE_W - dot_w);
        n_m_neg = perp ? M_THR : sat(THR_W + dot_w);
    end

    logic [SQ_W-1:0] r4_sqx, r4_sqy, r4_sqz;
    logic            r4_pos, r4_perp, r4_dot_pos;
    logic [OW-1:0]   r4_m_pos, r4_m_neg;

    always_ff @(posedge i_clk) begin
        r4_sqx     <= r3_rx * r3_rx;
        r4_sqy     <= r3_ry * r3_ry;
        r4_sqz     <= r3_rz * r3_rz;
        r4_pos     <= r3_nv || !cv_sum[CVS_W-1];
        r4_perp    <= perp;
        r4_dot_pos <= !r3_dot[RW-1] && (r3_dot != '0);
        r4_m_pos   <= n_m_pos;
        r4_m_neg   <= n_m_neg;
    end

    // stage 5: collinear test and final measure into the output register
    logic [CSQ_W-1:0] cross_sq;
    logic             coll;
    logic [OW-1:0]    n_measure;

    always_comb begin
        cross_sq = CSQ_W'(r4_sqx) + CSQ_W'(r4_sqy) + CSQ_W'(r4_sqz);
        coll     = XW'(cross_sq) <= XW'(r_tol_sq);
        if (coll) begin
            n_measure = r4_dot_pos ? '0 : M_TWO;
        end else if (r4_pos) begin
            n_measure = r4_m_pos;
        end else begin
            n_measure = r4_m_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        o_measure          <= n_measure;
        o_is_collinear     <= coll;
        o_is_perpendicular <= r4_perp;
    end

    assign o_valid = r_vld[DEPTH-1];

    // every result comes from an item that was taken earlier
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, DEPTH))
        else $error("result without a matching transfer");

    // collinear pairs land on zero or a half turn
    a_coll_measure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_collinear) |-> (o_measure == '0 || o_measure == M_TWO))
        else $error("collinear measure off 0 / 2");

    // perpendicular, non-collinear pairs land on a quarter or three quarters
    a_perp_measure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_perpendicular && !o_is_collinear) |->
            (o_measure == M_ONE || o_measure == M_THR))
        else $error("perpendicular measure off 1 / 3");

    // squared tolerance follows the tolerance register
    a_tol_sq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_cfg_we) && $past(i_rst_n)) |-> (r_tol_sq == r_tol * r_tol))
        else $error("squared tolerance out of step");

endmodule

/* tb/tb_vector_pseudo_angle_3d.sv */
`timescale 1ns / 1ps

module tb_vector_pseudo_angle_3d;

    localparam int     FRAC_BITS    = vpa3_pkg::DEF_FRAC_BITS;
    localparam int     OUT_W        = vpa3_pkg::OUT_W;
    localparam int     CFG_W        = vpa3_pkg::CFG_W;
    localparam longint ONE          = longint'(1) << FRAC_BITS;
    localparam int     LIMIT_CYCLES = 200000;
    localparam int     SHOW_MAX     = 10;

    typedef vpa3_pkg::t_comp t_comp;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
    } t_vec;

    typedef struct packed {
        t_vec a;
        t_vec b;
        t_vec view;
        logic no_view;
    } t_pair_item;

    typedef struct packed {
        logic [OUT_W-1:0] measure;
        logic             collinear;
        logic             perpendicular;
    } t_angle_result;

    // clock and block inputs, all known from time zero
    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    t_comp            i_a_x      = '0;
    t_comp            i_a_y      = '0;
    t_comp            i_a_z      = '0;
    t_comp            i_b_x      = '0;
    t_comp            i_b_y      = '0;
    t_comp            i_b_z      = '0;
    t_comp            i_view_x   = '0;
    t_comp            i_view_y   = '0;
    t_comp            i_view_z   = '0;
    logic             i_no_view  = 1'b0;

    logic             busy;
    logic             o_valid;
    logic [OUT_W-1:0] o_measure;
    logic             o_is_collinear;
    logic             o_is_perpendicular;

    // pairs waiting to be sent and angles waiting to come back
    t_pair_item       pairs_to_send[$];
    t_angle_result    angles_due[$];
    logic [CFG_W-1:0] tol_now = vpa3_pkg::TOL_RESET;

    t_pair_item       cur_pair;
    logic             took;
    logic             hold_off;
    int               taken_count = 0;
    int               fault_count = 0;
    int               shown_count = 0;
    int               cycle_count = 0;
    t_angle_result    want;
    t_angle_result    got;
    int               phase_tol[7];

    vector_pseudo_angle_3d #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_a_x              (i_a_x),
        .i_a_y              (i_a_y),
        .i_a_z              (i_a_z),
        .i_b_x              (i_b_x),
        .i_b_y              (i_b_y),
        .i_b_z              (i_b_z),
        .i_view_x           (i_view_x),
        .i_view_y           (i_view_y),
        .i_view_z           (i_view_z),
        .i_no_view          (i_no_view),
        .o_valid            (o_valid),
        .o_measure          (o_measure),
        .o_is_collinear     (o_is_collinear),
        .o_is_perpendicular (o_is_perpendicular)
    );

    always #1 i_clk = ~i_clk;

    // round a value with twice the fraction bits, halves away from zero
    function automatic longint round_to_frac(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint widen(t_comp v);
        return longint'(v);
    endfunction

    // expected measure and flags of one pair under the given tolerance
    function automatic t_angle_result pseudo_angle_of(t_pair_item p, logic [CFG_W-1:0] tol);
        longint ax, ay, az, bx, by, bz, vx, vy, vz;
        longint dot_q, cx, cy, cz, rx, ry, rz, cross_sq, tol_q, m, top;
        bit perp, coll, ccw;
        t_angle_result r;
        ax = widen(p.a.x);    ay = widen(p.a.y);    az = widen(p.a.z);
        bx = widen(p.b.x);    by = widen(p.b.y);    bz = widen(p.b.z);
        vx = widen(p.view.x); vy = widen(p.view.y); vz = widen(p.view.z);
        tol_q = longint'(tol);

        dot_q = round_to_frac(ax * bx + ay * by + az * bz);
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        rx = round_to_frac(cx);
        ry = round_to_frac(cy);
        rz = round_to_frac(cz);
        cross_sq = rx * rx + ry * ry + rz * rz;

        perp = ((dot_q < 0) ? -dot_q : dot_q) <= tol_q;
        coll = cross_sq <= tol_q * tol_q;
        ccw  = p.no_view || (cx * vx + cy * vy + cz * vz >= 0);

        // collinear wins over perpendicular, then the half turn picks the branch
        if (coll) begin
            m = (dot_q > 0) ? 0 : 2 * ONE;
        end else if (ccw) begin
            m = perp ? ONE : ONE - dot_q;
        end else begin
            m = perp ? 3 * ONE : 3 * ONE + dot_q;
        end
        top = 4 * ONE - 1;
        if (top > 65535) top = 65535;
        if (m < 0) m = 0;
        if (m > top) m = top;

        r.measure       = m[OUT_W-1:0];
        r.collinear     = coll;
        r.perpendicular = perp;
        return r;
    endfunction

    // random real in [-1, 1]
    function automatic real rand_real();
        return (real'($urandom_range(0, 2000000)) / 1000000.0) - 1.0;
    endfunction

    // scale a real direction to a unit vector in fixed point
    function automatic t_vec quantize(real x, real y, real z);
        real  n;
        t_vec v;
        n = $sqrt(x * x + y * y + z * z);
        if (n < 1.0e-9) begin
            v.x = t_comp'(16384);
            v.y = '0;
            v.z = '0;
        end else begin
            v.x = t_comp'($rtoi(x / n * 16384.0));
            v.y = t_comp'($rtoi(y / n * 16384.0));
            v.z = t_comp'($rtoi(z / n * 16384.0));
        end
        return v;
    endfunction

    function automatic t_vec rand_unit();
        real x, y, z;
        do begin
            x = rand_real();
            y = rand_real();
            z = rand_real();
        end while (x * x + y * y + z * z < 0.0025);
        return quantize(x, y, z);
    endfunction

    // move each component by up to span lsb either way
    function automatic t_vec nudge(t_vec v, int span);
        t_vec r;
        r.x = t_comp'(int'(v.x) + int'($urandom_range(0, 2 * span)) - span);
        r.y = t_comp'(int'(v.y) + int'($urandom_range(0, 2 * span)) - span);
        r.z = t_comp'(int'(v.z) + int'($urandom_range(0, 2 * span)) - span);
        return r;
    endfunction

    function automatic t_comp pick_edge();
        case ($urandom_range(0, 6))
            0:       return t_comp'(-32768);
            1:       return t_comp'(-16384);
            2:       return t_comp'(-1);
            3:       return t_comp'(0);
            4:       return t_comp'(1);
            5:       return t_comp'(16384);
            default: return t_comp'(32767);
        endcase
    endfunction

    function automatic t_pair_item make_pair(int ax, int ay, int az, int bx, int by, int bz,
                                             int vx, int vy, int vz, bit nv);
        t_pair_item p;
        p.a.x    = t_comp'(ax); p.a.y    = t_comp'(ay); p.a.z    = t_comp'(az);
        p.b.x    = t_comp'(bx); p.b.y    = t_comp'(by); p.b.z    = t_comp'(bz);
        p.view.x = t_comp'(vx); p.view.y = t_comp'(vy); p.view.z = t_comp'(vz);
        p.no_view = nv;
        return p;
    endfunction

    // random pairs: mostly unit vectors, many near the collinear and
    // perpendicular snaps, plus raw noise, edge values and views in the plane of a and b
    task automatic fill_pairs(int count);
        t_pair_item p;
        int         kind;
        int         span;
        logic [31:0] raw;
        real        ax, ay, az, rx, ry, rz;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       span = $urandom_range(0, 3);
                1:       span = $urandom_range(0, 40);
                default: span = $urandom_range(0, 300);
            endcase
            p.a       = rand_unit();
            p.b       = rand_unit();
            p.view    = rand_unit();
            p.no_view = ($urandom_range(0, 3) == 0);
            if (kind < 40) begin
                // plain unit pair
            end else if (kind < 55) begin
                p.b = nudge(p.a, span);
                if ($urandom_range(0, 1) == 1) begin
                    p.b.x = -p.b.x; p.b.y = -p.b.y; p.b.z = -p.b.z;
                end
            end else if (kind < 70) begin
                ax = real'(p.a.x); ay = real'(p.a.y); az = real'(p.a.z);
                rx = rand_real();  ry = rand_real();  rz = rand_real();
                p.b = nudge(quantize(ay * rz - az * ry, az * rx - ax * rz, ax * ry - ay * rx),
                            span);
            end else if (kind < 78) begin
                raw = $urandom(); p.a.x = raw[15:0]; p.a.y = raw[31:16];
                raw = $urandom(); p.a.z = raw[15:0]; p.b.x = raw[31:16];
                raw = $urandom(); p.b.y = raw[15:0]; p.b.z = raw[31:16];
                raw = $urandom(); p.view.x = raw[15:0]; p.view.y = raw[31:16];
                raw = $urandom(); p.view.z = raw[15:0]; p.no_view = raw[16];
            end else if (kind < 86) begin
                p.a.x = pick_edge(); p.a.y = pick_edge(); p.a.z = pick_edge();
                p.b.x = pick_edge(); p.b.y = pick_edge(); p.b.z = pick_edge();
                p.view.x = pick_edge(); p.view.y = pick_edge(); p.view.z = pick_edge();
            end else begin
                // view in the plane of a and b: cross.view is exactly zero
                p.view    = ($urandom_range(0, 1) == 1) ? p.a : p.b;
                p.no_view = 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    p.view.x = -p.view.x; p.view.y = -p.view.y; p.view.z = -p.view.z;
                end
            end
            pairs_to_send.push_back(p);
        end
    endtask

    // wait until every pair is sent and every angle is back
    task automatic drain();
        @(negedge i_clk);
        while (pairs_to_send.size() != 0 || start || angles_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_tolerance(logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        tol_now     = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    // driver: one transfer per edge with start high and busy low, with random gaps outside transfers 300 to 499
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;
            if (took) begin
                angles_due.push_back(pseudo_angle_of(cur_pair, tol_now));
                taken_count++;
            end
            if (!start || took) begin
                hold_off = (taken_count < 300 || taken_count >= 500)
                           && ($urandom_range(0, 99) < 13);
                if (pairs_to_send.size() != 0 && !hold_off) begin
                    cur_pair  = pairs_to_send.pop_front();
                    start     <= 1'b1;
                    i_a_x     <= cur_pair.a.x;
                    i_a_y     <= cur_pair.a.y;
                    i_a_z     <= cur_pair.a.z;
                    i_b_x     <= cur_pair.b.x;
                    i_b_y     <= cur_pair.b.y;
                    i_b_z     <= cur_pair.b.z;
                    i_view_x  <= cur_pair.view.x;
                    i_view_y  <= cur_pair.view.y;
                    i_view_z  <= cur_pair.view.z;
                    i_no_view <= cur_pair.no_view;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest expected angle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            got.measure       = o_measure;
            got.collinear     = o_is_collinear;
            got.perpendicular = o_is_perpendicular;
            if (angles_due.size() == 0) begin
                fault_count++;
                if (shown_count < SHOW_MAX) begin
                    shown_count++;
                    $display("unexpected result: measure=%0d coll=%0b perp=%0b",
                             got.measure, got.collinear, got.perpendicular);
                end
            end else begin
                want = angles_due.pop_front();
                if (got.measure !== want.measure || got.collinear !== want.collinear
                    || got.perpendicular !== want.perpendicular) begin
                    fault_count++;
                    if (shown_count < SHOW_MAX) begin
                        shown_count++;
                        $display("mismatch: measure exp %0d got %0d, coll exp %0b got %0b, %s",
                                 want.measure, got.measure, want.collinear, got.collinear,
                                 $sformatf("perp exp %0b got %0b",
                                           want.perpendicular, got.perpendicular));
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** vector_pseudo_angle_3d: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed pairs under the reset tolerance
        @(negedge i_clk);
        // same and opposite directions
        pairs_to_send.push_back(make_pair(16384, 0, 0, 16384, 0, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, -16384, 0, 0, 0, 0, 16384, 0));
        // right angle seen from both sides, right-hand rule, view in the plane
        pairs_to_send.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, -16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, -16384, 1));
        pairs_to_send.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 16384, 0, 0, 0));
        // sixty and one hundred twenty degrees, both half turns
        pairs_to_send.push_back(make_pair(16384, 0, 0, 8192, 14189, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, 8192, 14189, 0, 0, 0, -16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, -8192, 14189, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, -8192, 14189, 0, 0, 0, -16384, 0));
        // zero vector: collinear and perpendicular at once
        pairs_to_send.push_back(make_pair(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0));
        // full-scale patterns
        pairs_to_send.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, 0));
        pairs_to_send.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768,
                                          32767, -32768, 32767, 0));
        // saturation at the top and at zero
        pairs_to_send.push_back(make_pair(32767, 32767, 0, -32768, -32768, 1000,
                                          0, 0, 16384, 1));
        pairs_to_send.push_back(make_pair(32767, 32767, 0, -32768, -32768, 1000,
                                          -16384, 16384, 0, 0));
        // dot right at and just past the tolerance
        pairs_to_send.push_back(make_pair(16384, 0, 0, 1, 16383, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, 2, 16383, 0, 0, 0, 16384, 0));
        // dot rounding on a half, both signs
        pairs_to_send.push_back(make_pair(8192, 0, 0, 1, 16384, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(8192, 0, 0, -1, 16384, 0, 0, 0, -16384, 0));
        // cross magnitude at and just past the tolerance
        pairs_to_send.push_back(make_pair(16384, 0, 0, 16384, 1, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, 16384, 2, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(16384, 0, 0, -16384, 2, 0, 0, 0, -16384, 0));
        // cross rounding on a half, both signs
        pairs_to_send.push_back(make_pair(8192, 0, 0, 16384, 1, 0, 0, 0, 16384, 0));
        pairs_to_send.push_back(make_pair(8192, 0, 0, 16384, -1, 0, 0, 0, 16384, 0));
        drain();

        // random pairs over a range of tolerances, extremes included
        phase_tol[0] = 0;
        phase_tol[1] = 120;
        phase_tol[2] = $urandom_range(1, 4000);
        phase_tol[3] = 16384;
        phase_tol[4] = 32767;
        phase_tol[5] = 1;
        phase_tol[6] = $urandom_range(0, 32767);
        for (int ph = 0; ph < 7; ph++) begin
            set_tolerance(phase_tol[ph][CFG_W-1:0]);
            @(negedge i_clk);
            fill_pairs(115);
            drain();
        end

        if (angles_due.size() != 0) fault_count++;
        if (fault_count == 0) begin
            $display("** vector_pseudo_angle_3d: PASSED **");
        end else begin
            $display("** vector_pseudo_angle_3d: FAILED **");
        end
        $finish;
    end

endmodule
